@@ hdl/ps2tap_pkg.sv @@
package ps2tap_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MOVE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TIME_LIMIT = 2'd2;

    localparam logic        RST_WHEEL_ENABLE   = 1'b0;
    localparam logic [7:0]  RST_TAP_MOVE_LIMIT = 8'd8;
    localparam logic [15:0] RST_TAP_TIME_LIMIT = 16'd150;

    // Byte phase within a packet.
    localparam logic [1:0] PHASE_LAST_STD   = 2'd2;
    localparam logic [1:0] PHASE_LAST_WHEEL = 2'd3;

    // Bit 3 of the first packet byte is always set by the device.
    localparam int SYNC_BIT = 3;

    localparam int SUM_W = 16;

    // Packet queue between front and back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [2:0] BTN_NONE = 3'd0;
    localparam logic [2:0] BTN_LEFT = 3'd1;

    typedef struct packed {
        logic        wheel_enable;
        logic [7:0]  tap_move_limit;
        logic [15:0] tap_time_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  btn;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [3:0]  dw;
        logic [31:0] now;
    } t_pkt;

endpackage

@@ hdl/ps2tap_front.sv @@
module ps2tap_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_from_aux,
    input  logic [31:0]        i_now_ticks,
    input  logic               i_wheel_enable,
    input  logic               i_fifo_full,
    output logic               o_push,
    output ps2tap_pkg::t_pkt   o_pkt
);
    import ps2tap_pkg::*;

    logic [1:0] r_phase;
    logic [7:0] r_bytes [3];
    logic       aux_beat;
    logic       pkt_done;
    logic [1:0] last_phase;

    assign o_in_ready = !i_fifo_full;
    assign aux_beat   = i_in_valid && o_in_ready && i_from_aux;
    assign last_phase = i_wheel_enable ? PHASE_LAST_WHEEL : PHASE_LAST_STD;
    assign pkt_done   = (r_phase >= last_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (aux_beat) begin
            r_phase <= pkt_done ? 2'd0 : r_phase + 2'd1;
        end
    end

    // The fourth byte is never stored; only its wheel nibble is used.
    always_ff @(posedge i_clk) begin
        if (aux_beat && r_phase != PHASE_LAST_WHEEL) begin
            r_bytes[r_phase] <= i_rx_byte;
        end
    end

    // Packets whose first byte lacks the sync bit are dropped here.
    assign o_push = aux_beat && pkt_done && r_bytes[0][SYNC_BIT];

    always_comb begin
        o_pkt.btn = r_bytes[0][2:0];
        o_pkt.dx  = r_bytes[1];
        o_pkt.dy  = (r_phase == PHASE_LAST_STD) ? i_rx_byte : r_bytes[2];
        o_pkt.dw  = i_wheel_enable ? i_rx_byte[3:0] : 4'd0;
        o_pkt.now = i_now_ticks;
    end

endmodule

@@ hdl/ps2tap_fifo.sv @@
module ps2tap_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ps2tap_pkg::t_pkt   i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output ps2tap_pkg::t_pkt   o_data
);
    import ps2tap_pkg::*;

    t_pkt                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("packet queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("packet queue read while empty");
`endif

endmodule

@@ hdl/ps2tap_back.sv @@
module ps2tap_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pkt_valid,
    input  ps2tap_pkg::t_pkt   i_pkt,
    output logic               o_pop,
    input  ps2tap_pkg::t_cfg   i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_dx,
    output logic [7:0]         o_dy,
    output logic [3:0]         o_dw,
    output logic [2:0]         o_btn,
    output logic               o_last
);
    import ps2tap_pkg::*;

    logic             r_out_valid;
    logic [7:0]       r_out_dx;
    logic [7:0]       r_out_dy;
    logic [3:0]       r_out_dw;
    logic [2:0]       r_out_btn;
    logic             r_out_last;
    logic             r_rel_pend;
    logic             r_touch_active;
    logic             r_touch_moved;
    logic [SUM_W-1:0] r_sum_x;
    logic [SUM_W-1:0] r_sum_y;
    logic [31:0]      r_touch_start;

    logic             n_touch_active;
    logic             n_touch_moved;
    logic [SUM_W-1:0] n_sum_x;
    logic [SUM_W-1:0] n_sum_y;
    logic [31:0]      n_touch_start;

    logic             slot_free;
    logic             moving;
    logic             is_tap;
    logic [8:0]       abs_x;
    logic [8:0]       abs_y;
    logic [SUM_W:0]   add_x;
    logic [SUM_W:0]   add_y;
    logic [SUM_W-1:0] sat_x;
    logic [SUM_W-1:0] sat_y;
    logic [31:0]      elapsed;

    assign slot_free = !r_out_valid || i_out_ready;
    assign o_pop     = i_pkt_valid && slot_free && !r_rel_pend;
    assign moving    = (i_pkt.dx != 8'd0) || (i_pkt.dy != 8'd0);

    assign abs_x = i_pkt.dx[7] ? 9'd256 - {1'b0, i_pkt.dx} : {1'b0, i_pkt.dx};
    assign abs_y = i_pkt.dy[7] ? 9'd256 - {1'b0, i_pkt.dy} : {1'b0, i_pkt.dy};
    assign add_x = {1'b0, r_sum_x} + {8'd0, abs_x};
    assign add_y = {1'b0, r_sum_y} + {8'd0, abs_y};
    assign sat_x = add_x[SUM_W] ? '1 : add_x[SUM_W-1:0];
    assign sat_y = add_y[SUM_W] ? '1 : add_y[SUM_W-1:0];
    assign elapsed = i_pkt.now - r_touch_start;

    always_comb begin
        n_touch_active = r_touch_active;
        n_touch_moved  = r_touch_moved;
        n_sum_x        = r_sum_x;
        n_sum_y        = r_sum_y;
        n_touch_start  = r_touch_start;
        is_tap         = 1'b0;
        if (i_pkt.btn == BTN_NONE) begin
            if (moving && !r_touch_active) begin
                n_touch_active = 1'b1;
                n_touch_moved  = 1'b0;
                n_sum_x        = '0;
                n_sum_y        = '0;
                n_touch_start  = i_pkt.now;
            end else if (moving) begin
                n_sum_x = sat_x;
                n_sum_y = sat_y;
                if (sat_x > {8'd0, i_cfg.tap_move_limit} ||
                    sat_y > {8'd0, i_cfg.tap_move_limit}) begin
                    n_touch_moved = 1'b1;
                end
            end else if (r_touch_active) begin
                n_touch_active = 1'b0;
                is_tap = !r_touch_moved && (elapsed < {16'd0, i_cfg.tap_time_limit});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_rel_pend     <= 1'b0;
            r_touch_active <= 1'b0;
            r_touch_moved  <= 1'b0;
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_touch_start  <= '0;
        end else if (slot_free) begin
            if (r_rel_pend) begin
                r_out_valid <= 1'b1;
                r_rel_pend  <= 1'b0;
            end else if (o_pop) begin
                r_out_valid    <= 1'b1;
                r_rel_pend     <= is_tap;
                r_touch_active <= n_touch_active;
                r_touch_moved  <= n_touch_moved;
                r_sum_x        <= n_sum_x;
                r_sum_y        <= n_sum_y;
                r_touch_start  <= n_touch_start;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            if (r_rel_pend) begin
                r_out_dx   <= 8'd0;
                r_out_dy   <= 8'd0;
                r_out_dw   <= 4'd0;
                r_out_btn  <= BTN_NONE;
                r_out_last <= 1'b1;
            end else if (o_pop && is_tap) begin
                r_out_dx   <= 8'd0;
                r_out_dy   <= 8'd0;
                r_out_dw   <= 4'd0;
                r_out_btn  <= BTN_LEFT;
                r_out_last <= 1'b0;
            end else if (o_pop) begin
                r_out_dx   <= i_pkt.dx;
                r_out_dy   <= i_pkt.dy;
                r_out_dw   <= i_pkt.dw;
                r_out_btn  <= i_pkt.btn;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dx        = r_out_dx;
    assign o_dy        = r_out_dy;
    assign o_dw        = r_out_dw;
    assign o_btn       = r_out_btn;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel_pend |-> r_out_valid && r_out_btn == BTN_LEFT && !r_out_last)
        else $error("release pending without a press event in the output stage");

    a_touch_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_touch_active) |-> r_sum_x == '0 && r_sum_y == '0 && !r_touch_moved)
        else $error("touch started with stale accumulators");

    a_no_pop_during_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel_pend |-> !o_pop)
        else $error("packet taken while a release event is still owed");
`endif

endmodule

@@ hdl/ps2_mouse_packet_tap_decoder_core.sv @@
// With the queue and output stage empty, the packet is written into the queue at the edge
// that accepts its closing byte and its first event is then loaded into the output stage;
// a tap click sends its release event in the cycle after the press beat is taken.
// Throughput: one byte per cycle while the two-entry packet queue has room; the output
// stage drains one event per cycle while the consumer is ready; a tap packet yields two events.
// Reset (synchronous, active low) clears the byte phase, the touch tracker, the queue and
// the output valid, and loads wheel_enable 0, tap_move_limit 8 and tap_time_limit 150.
module ps2_mouse_packet_tap_decoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ps2tap_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ps2tap_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [7:0]                            i_rx_byte,
    input  logic                                  i_from_aux,
    input  logic [31:0]                           i_now_ticks,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [7:0]                     o_delta_x,
    output logic signed [7:0]                     o_delta_y,
    output logic signed [3:0]                     o_delta_wheel,
    output logic [2:0]                            o_button_bits,
    output logic                                  o_last_event
);
    import ps2tap_pkg::*;

    // The block is split in two halves joined by a small packet queue. The front
    // half takes one beat per cycle while the queue has room, collects the three or four
    // bytes of a packet and drops packets whose first byte lacks the sync bit. The back half
    // runs the tap tracker on each queued packet and turns it into one or two events held
    // in an output register, so a stalled consumer backs up the queue and then the input.

    t_cfg r_cfg;
    logic fifo_full;
    logic fifo_valid;
    logic push;
    logic pop;
    t_pkt front_pkt;
    t_pkt queue_pkt;
    logic [7:0] out_dx;
    logic [7:0] out_dy;
    logic [3:0] out_dw;

    // Configuration registers. The user must send writes only while the block is idle;
    // the block does not enforce it. Both halves read them without any staging.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_enable   <= RST_WHEEL_ENABLE;
            r_cfg.tap_move_limit <= RST_TAP_MOVE_LIMIT;
            r_cfg.tap_time_limit <= RST_TAP_TIME_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WHEEL_ENABLE:   r_cfg.wheel_enable   <= i_cfg_data[0];
                CFG_TAP_MOVE_LIMIT: r_cfg.tap_move_limit <= i_cfg_data[7:0];
                CFG_TAP_TIME_LIMIT: r_cfg.tap_time_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Packet assembly. Ready depends only on queue space, never on the byte.
    ps2tap_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_from_aux     (i_from_aux),
        .i_now_ticks    (i_now_ticks),
        .i_wheel_enable (r_cfg.wheel_enable),
        .i_fifo_full    (fifo_full),
        .o_push         (push),
        .o_pkt          (front_pkt)
    );

    // Complete, well-formed packets waiting for the tap tracker.
    ps2tap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_pkt),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_full  (fifo_full),
        .o_data  (queue_pkt)
    );

    // Tap tracking and event generation. A short still touch becomes a left
    // press followed by a release; everything else passes the packet through.
    ps2tap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (fifo_valid),
        .i_pkt       (queue_pkt),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dx        (out_dx),
        .o_dy        (out_dy),
        .o_dw        (out_dw),
        .o_btn       (o_button_bits),
        .o_last      (o_last_event)
    );

    // The motion bytes are two's complement as they come from the device.
    assign o_delta_x     = $signed(out_dx);
    assign o_delta_y     = $signed(out_dy);
    assign o_delta_wheel = $signed(out_dw);

endmodule

@@ test/ps2_mouse_packet_tap_decoder_core_test.sv @@
module ps2_mouse_packet_tap_decoder_core_test;
    import ps2tap_pkg::*;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT    = 400000;
    // Length of the deliberate output stall that backs the block up into its input.
    localparam int RX_HOLD_CYCLES = 200;
    // Cycles allowed after the last expected event before config writes or the end.
    localparam int SETTLE_CYCLES  = 8;

    // One event as it leaves the block, in port order.
    typedef struct packed {
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [3:0] dw;
        logic [2:0]        btn;
        logic              last;
    } t_mouse_event;

    // Shadow of the decoder: register copies, packet assembly, touch tracking, and the
    // events still owed by the block, oldest first.
    class mouse_event_tracker;
        t_mouse_event awaited_events[$];
        bit           wheel_on;
        bit [7:0]     move_limit;
        bit [15:0]    time_limit;
        bit [7:0]     pkt_store[3];
        bit [1:0]     byte_pos;
        bit           touching;
        bit           touch_moved;
        bit [15:0]    travel_x;
        bit [15:0]    travel_y;
        bit [31:0]    touch_t0;
        int           fault_count;

        function new();
            wheel_on    = RST_WHEEL_ENABLE;
            move_limit  = RST_TAP_MOVE_LIMIT;
            time_limit  = RST_TAP_TIME_LIMIT;
            byte_pos    = '0;
            touching    = 1'b0;
            touch_moved = 1'b0;
            travel_x    = '0;
            travel_y    = '0;
            touch_t0    = '0;
            fault_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WHEEL_ENABLE:   wheel_on   = val[0];
                CFG_TAP_MOVE_LIMIT: move_limit = val[7:0];
                CFG_TAP_TIME_LIMIT: time_limit = val[15:0];
                default: ;
            endcase
        endfunction

        // Distance travelled saturates at the top of the 16-bit range.
        function bit [15:0] add_travel(bit [15:0] acc, bit [7:0] raw);
            int unsigned mag;
            int unsigned total;
            mag   = raw[7] ? 256 - raw : raw;
            total = acc + mag;
            return (total > 16'hFFFF) ? 16'hFFFF : total[15:0];
        endfunction

        function void queue_event(bit [7:0] dx, bit [7:0] dy, bit [3:0] dw, bit [2:0] btn,
                                  bit last);
            t_mouse_event ev;
            ev.dx   = dx;
            ev.dy   = dy;
            ev.dw   = dw;
            ev.btn  = btn;
            ev.last = last;
            awaited_events.push_back(ev);
        endfunction

        // Called once per accepted input beat.
        function void note_byte(bit [7:0] b, bit aux, bit [31:0] ticks);
            bit [1:0]  final_pos;
            bit [2:0]  btn;
            bit [7:0]  dx;
            bit [7:0]  dy;
            bit [3:0]  dw;
            bit [31:0] elapsed;
            final_pos = wheel_on ? PHASE_LAST_WHEEL : PHASE_LAST_STD;
            if (!aux) return;
            // A byte arriving at position 3 is never stored; with the wheel turned off
            // it simply closes the packet built from the first three bytes.
            if (byte_pos < 2'd3) pkt_store[byte_pos] = b;
            if (byte_pos < final_pos) begin
                byte_pos = byte_pos + 2'd1;
                return;
            end
            byte_pos = '0;
            if (!pkt_store[0][SYNC_BIT]) return;
            btn = pkt_store[0][2:0];
            dx  = pkt_store[1];
            dy  = pkt_store[2];
            dw  = wheel_on ? b[3:0] : 4'd0;
            if (btn == BTN_NONE) begin
                if (dx != 0 || dy != 0) begin
                    if (!touching) begin
                        touching    = 1'b1;
                        touch_moved = 1'b0;
                        travel_x    = '0;
                        travel_y    = '0;
                        touch_t0    = ticks;
                    end else begin
                        travel_x = add_travel(travel_x, dx);
                        travel_y = add_travel(travel_y, dy);
                        if (travel_x > move_limit || travel_y > move_limit)
                            touch_moved = 1'b1;
                    end
                end else if (touching) begin
                    touching = 1'b0;
                    elapsed  = ticks - touch_t0;
                    if (!touch_moved && elapsed < {16'd0, time_limit}) begin
                        queue_event(8'd0, 8'd0, 4'd0, BTN_LEFT, 1'b0);
                        queue_event(8'd0, 8'd0, 4'd0, BTN_NONE, 1'b1);
                        return;
                    end
                end
            end
            queue_event(dx, dy, dw, btn, 1'b1);
        endfunction

        function void check_event(t_mouse_event got);
            t_mouse_event want;
            if (awaited_events.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected event: dx=%0d dy=%0d dw=%0d btn=%0d last=%0d",
                             got.dx, got.dy, got.dw, got.btn, got.last);
                return;
            end
            want = awaited_events.pop_front();
            if (got.dx !== want.dx || got.dy !== want.dy || got.dw !== want.dw ||
                got.btn !== want.btn || got.last !== want.last) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("event mismatch: expected dx=%0d dy=%0d dw=%0d btn=%0d last=%0d, %s",
                             want.dx, want.dy, want.dw, want.btn, want.last,
                             $sformatf("got dx=%0d dy=%0d dw=%0d btn=%0d last=%0d",
                                       got.dx, got.dy, got.dw, got.btn, got.last));
            end
        endfunction

        function int pending_count();
            return awaited_events.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  o_in_ready;
    logic [7:0]            rx_byte;
    logic                  from_aux;
    logic [31:0]           now_ticks;
    logic                  o_out_valid;
    logic                  out_ready;
    logic signed [7:0]     o_delta_x;
    logic signed [7:0]     o_delta_y;
    logic signed [3:0]     o_delta_wheel;
    logic [2:0]            o_button_bits;
    logic                  o_last_event;

    mouse_event_tracker tracker;

    // Stimulus state shared by the driving tasks.
    bit          no_idle;      // when set, neither side inserts idle cycles
    bit          rx_hold_req;  // asks the receiver for one long stall
    bit [31:0]   tick_now;     // millisecond clock seen by the mouse
    int unsigned aux_beats;    // mouse bytes accepted so far
    int unsigned cycle_count;

    ps2_mouse_packet_tap_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (rx_byte),
        .i_from_aux    (from_aux),
        .i_now_ticks   (now_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_delta_x     (o_delta_x),
        .o_delta_y     (o_delta_y),
        .o_delta_wheel (o_delta_wheel),
        .o_button_bits (o_button_bits),
        .o_last_event  (o_last_event)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is cut off if a handshake never completes.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every event beat that the receiver takes is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready)
            tracker.check_event({o_delta_x, o_delta_y, o_delta_wheel, o_button_bits,
                                 o_last_event});
    end

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 8);
    endfunction

    // Receiver: a random stall before each event beat, and one long hold on request.
    initial begin
        int stall;
        out_ready = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            stall = draw_wait();
            if (stall != 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Offers one byte after a random gap and returns at the edge where it is taken.
    // Valid stays high on return so that a back-to-back beat needs no extra edge.
    task automatic send_beat(input logic [7:0] b, input logic aux, input logic [31:0] ticks);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
        @(negedge i_clk);
        in_valid  = 1'b1;
        rx_byte   = b;
        from_aux  = aux;
        now_ticks = ticks;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_byte(b, aux, ticks);
        if (aux) aux_beats++;
    endtask

    // Waits until every owed event has come out and the pipeline has settled.
    task automatic drain_block();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input bit wheel, input bit [7:0] move_lim,
                              input bit [15:0] time_lim);
        drain_block();
        cfg_write(CFG_WHEEL_ENABLE, {15'd0, wheel});
        cfg_write(CFG_TAP_MOVE_LIMIT, {8'd0, move_lim});
        cfg_write(CFG_TAP_TIME_LIMIT, time_lim);
    endtask

    // Small finger motion, zero now and then.
    function automatic bit [7:0] small_delta();
        int unsigned pick;
        bit [7:0]    mag;
        pick = $urandom_range(0, 9);
        mag  = 8'($urandom_range(1, 5));
        if (pick < 2) return 8'd0;
        if (pick < 8) return $urandom_range(0, 1) ? mag : -mag;
        return 8'($urandom);
    endfunction

    // Any motion, with the range ends well represented.
    function automatic bit [7:0] wide_delta();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h7F;
            2: return 8'h80;
            3: return small_delta();
            default: return 8'($urandom);
        endcase
    endfunction

    // Sends one packet in the current wheel mode; stray non-mouse bytes may sneak in
    // between its bytes, as they do on a shared controller.
    task automatic send_packet(input bit [2:0] btn, input bit [7:0] dx, input bit [7:0] dy,
                               input bit sync);
        bit [7:0] bytes[4];
        int       n;
        bytes[0] = {4'($urandom), sync, btn};
        bytes[1] = dx;
        bytes[2] = dy;
        bytes[3] = 8'($urandom);
        n = tracker.wheel_on ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, $urandom);
            tick_now += $urandom_range(0, 3);
            send_beat(bytes[i], 1'b1, tick_now);
        end
    endtask

    // A touch: start on motion, a few more moves, then a still packet that ends it.
    task automatic tap_gesture();
        int moves;
        moves = $urandom_range(0, 4);
        send_packet(BTN_NONE, 8'($urandom_range(1, 3)), small_delta(), 1'b1);
        for (int i = 0; i < moves; i++) begin
            tick_now += $urandom_range(0, 40);
            send_packet(BTN_NONE, small_delta(), small_delta(), 1'b1);
        end
        tick_now += $urandom_range(0, 60);
        send_packet(BTN_NONE, 8'd0, 8'd0, 1'b1);
    endtask

    // Mostly well-formed traffic with random content, plus broken packets and noise.
    task automatic run_phase(input int unsigned n_items);
        int unsigned first;
        int unsigned pick;
        first = aux_beats;
        while (aux_beats - first < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                tap_gesture();
            else if (pick < 75)
                send_packet($urandom_range(0, 3) == 0 ? 3'($urandom) : BTN_NONE,
                            wide_delta(), wide_delta(), 1'b1);
            else if (pick < 85)
                send_packet(3'($urandom), wide_delta(), wide_delta(), 1'b0);
            else if (pick < 93)
                // A lone byte knocks the packet framing out of step.
                send_beat(8'($urandom), 1'b1, tick_now);
            else
                send_beat(8'($urandom), 1'b0, $urandom);
        end
    endtask

    initial begin
        tracker     = new();
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        from_aux    = 1'b0;
        now_ticks   = '0;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        tick_now    = 32'd1000;
        aux_beats   = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, starting from the reset register values.
        // A byte not flagged as mouse data is dropped.
        send_beat(8'hFF, 1'b0, 32'hFFFF_FFFF);
        // All three buttons with both deltas at their extremes.
        send_beat(8'h0F, 1'b1, 32'd100);
        send_beat(8'h7F, 1'b1, 32'd101);
        send_beat(8'h80, 1'b1, 32'd102);
        // First byte without the sync bit: the whole packet is swallowed.
        send_beat(8'h07, 1'b1, 32'd103);
        send_beat(8'hFF, 1'b1, 32'd104);
        send_beat(8'h08, 1'b1, 32'd105);
        // A quick tap whose duration wraps the tick counter: press and release come out.
        send_beat(8'h08, 1'b1, 32'hFFFF_FFEE);
        send_beat(8'h01, 1'b1, 32'hFFFF_FFEF);
        send_beat(8'h00, 1'b1, 32'hFFFF_FFF0);
        send_beat(8'h08, 1'b1, 32'h0000_000E);
        send_beat(8'h00, 1'b1, 32'h0000_000F);
        send_beat(8'h00, 1'b1, 32'h0000_0010);
        // Wheel mode, with the most negative wheel step.
        drain_block();
        cfg_write(CFG_WHEEL_ENABLE, 16'd1);
        send_beat(8'h08, 1'b1, 32'd200);
        send_beat(8'h80, 1'b1, 32'd201);
        send_beat(8'h7F, 1'b1, 32'd202);
        send_beat(8'hF8, 1'b1, 32'd203);
        // The wheel is switched off while a four-byte packet waits for its last byte:
        // that byte then just closes the packet.
        send_beat(8'h09, 1'b1, 32'd300);
        send_beat(8'h05, 1'b1, 32'd301);
        send_beat(8'hFB, 1'b1, 32'd302);
        drain_block();
        cfg_write(CFG_WHEEL_ENABLE, 16'd0);
        send_beat(8'hAA, 1'b1, 32'd303);

        // Random part, one register setting per phase, the extremes among them.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: set_config(1'b1, 8'd0, 16'd0);
                1: set_config(1'b0, 8'd255, 16'd65535);
                2: set_config(1'b1, RST_TAP_MOVE_LIMIT, RST_TAP_TIME_LIMIT);
                3: set_config(1'b0, 8'($urandom_range(0, 20)), 16'($urandom_range(20, 300)));
                4: set_config(1'b1, 8'($urandom), 16'($urandom_range(50, 400)));
                default: set_config(1'($urandom), 8'($urandom_range(0, 30)),
                                    16'($urandom_range(0, 3) == 0 ? $urandom
                                                                  : $urandom_range(10, 200)));
            endcase
            tick_now = $urandom;
            no_idle  = (phase == 2 || phase == 5);
            // With the sender running flat out, a long receiver stall fills the block up.
            if (phase == 2) rx_hold_req = 1'b1;
            run_phase(100);
        end

        drain_block();
        if (tracker.fault_count == 0 && tracker.pending_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d events never seen",
                     tracker.fault_count, tracker.pending_count());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
